// ----- rtl/core/bmbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmbc_pkg
// Shared constants, types and arithmetic helpers for the bed mesh correction.
// ----------------------------------------------------------------------------
package bmbc_pkg;

  // grid geometry defaults
  localparam int POINTS_X_DEF = 16;
  localparam int POINTS_Y_DEF = 16;

  // mesh store layout: three meshes of 256 slots, slot = mesh*256 + col*16 + row
  localparam int MESH_SLOTS = 256;
  localparam int MESH_COUNT = 3;
  localparam int MEM_DEPTH  = MESH_COUNT * MESH_SLOTS;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  // mesh selector codes
  localparam logic [1:0] MESH_ORIG   = 2'd0;
  localparam logic [1:0] MESH_FIRST  = 2'd1;
  localparam logic [1:0] MESH_SECOND = 2'd2;

  // corner source codes
  localparam logic [1:0] HOW_DIRECT = 2'd0;
  localparam logic [1:0] HOW_FIRST  = 2'd1;
  localparam logic [1:0] HOW_BLEND  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_CPU_X     = 3'd2;
  localparam logic [2:0] REG_CPU_Y     = 3'd3;
  localparam logic [2:0] REG_ACTIVE    = 3'd4;
  localparam logic [2:0] REG_BED_TEMP  = 3'd5;
  localparam logic [2:0] REG_T1        = 3'd6;
  localparam logic [2:0] REG_T2        = 3'd7;

  // datapath widths
  localparam int CORNER_W = 48;   // Q.16 corner and blend values
  localparam int DVD_W    = 43;   // blend dividend and quotient
  localparam int PROD_W   = 64;   // lerp product

  typedef logic signed [CORNER_W-1:0] corner_t;

  // round to nearest of x / 65536, halves away from zero
  function automatic logic signed [PROD_W-1:0] rdiv16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] mag;
    begin
      if (x < 0) begin
        mag = (-x + PROD_W'(32768)) >>> 16;
        rdiv16 = -mag;
      end else begin
        rdiv16 = (x + PROD_W'(32768)) >>> 16;
      end
    end
  endfunction

  // store address of one point
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] mesh,
                                                  input logic [3:0] col,
                                                  input logic [3:0] row);
    slot_addr = {mesh, col, row};
  endfunction

endpackage

// ----- rtl/core/bed_mesh_bilinear_correction.sv -----
// ----------------------------------------------------------------------------
// bed_mesh_bilinear_correction
// Bilinear Z correction over three stored height meshes, with temperature
// blending of the first and second mesh.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------
//  command   | action pos_x pos_y point_col point_row   | start high, busy low
//            | point_height                             |
//  result    | z_offset mesh_error                      | done, one cycle
//  config    | cfg_index cfg_data                       | cfg_we, no wait
//
//  a point write reads the old value, then writes back and counts.
//  a query on the original mesh or equal temperatures locates the cell in
//  two states, makes two memory reads per corner and three shared lerp passes.
//  a blended query also runs the bit-serial divider for every corner
//  (43 steps per corner, four corners).
//  after reset the store is cleared one entry a cycle, busy high until all
//  768 are clear. the result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module bed_mesh_bilinear_correction
  import bmbc_pkg::*;
#(
  parameter int POINTS_X = POINTS_X_DEF,
  parameter int POINTS_Y = POINTS_Y_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [3:0]         point_col,
  input  logic [3:0]         point_row,
  input  logic signed [15:0] point_height,
  output logic               done,
  output logic signed [15:0] z_offset,
  output logic               mesh_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // sequencer codes
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WR     = 4'd2;
  localparam logic [3:0] S_LOC    = 4'd3;
  localparam logic [3:0] S_CELL   = 4'd4;
  localparam logic [3:0] S_RD1    = 4'd5;
  localparam logic [3:0] S_RD2    = 4'd6;
  localparam logic [3:0] S_MULP   = 4'd7;
  localparam logic [3:0] S_DIVLD  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_DIVEND = 4'd10;
  localparam logic [3:0] S_LA     = 4'd11;
  localparam logic [3:0] S_LB     = 4'd12;
  localparam logic [3:0] S_LC     = 4'd13;
  localparam logic [3:0] S_LD     = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  // configuration registers
  logic signed [23:0] grid_origin_x, grid_origin_y;
  logic [23:0]        cells_per_unit_x, cells_per_unit_y;
  logic [1:0]         active_mesh;
  logic [8:0]         bed_target_temp, first_mesh_temp, second_mesh_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_origin_x    <= '0;
      grid_origin_y    <= '0;
      cells_per_unit_x <= '0;
      cells_per_unit_y <= '0;
      active_mesh      <= '0;
      bed_target_temp  <= '0;
      first_mesh_temp  <= '0;
      second_mesh_temp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: grid_origin_x    <= cfg_data;
        REG_ORIGIN_Y: grid_origin_y    <= cfg_data;
        REG_CPU_X:    cells_per_unit_x <= cfg_data;
        REG_CPU_Y:    cells_per_unit_y <= cfg_data;
        REG_ACTIVE:   active_mesh      <= cfg_data[1:0];
        REG_BED_TEMP: bed_target_temp  <= cfg_data[8:0];
        REG_T1:       first_mesh_temp  <= cfg_data[8:0];
        REG_T2:       second_mesh_temp <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // mesh select, unused code acts as original
  logic [1:0] mesh_sel;
  assign mesh_sel = (active_mesh == MESH_FIRST || active_mesh == MESH_SECOND) ?
                    active_mesh : MESH_ORIG;

  // blend temperatures
  logic [9:0]         temp_sum;
  logic [8:0]         temp_eff;
  logic signed [10:0] temp_dt, temp_den;
  logic [9:0]         den_mag;
  assign temp_sum = {1'b0, first_mesh_temp} + {1'b0, second_mesh_temp};
  assign temp_eff = (bed_target_temp != '0) ? bed_target_temp : temp_sum[9:1];
  assign temp_dt  = $signed({2'b0, temp_eff}) - $signed({2'b0, first_mesh_temp});
  assign temp_den = $signed({2'b0, second_mesh_temp}) - $signed({2'b0, first_mesh_temp});
  assign den_mag  = temp_den[10] ? 10'(-temp_den) : temp_den[9:0];

  // state
  logic [3:0]          state, state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [8:0]          nz_cnt [2];

  // latched item
  logic               act_q;
  logic signed [23:0] pos_x_q, pos_y_q;
  logic [3:0]         col_q, row_q;
  logic signed [15:0] height_q;
  logic [1:0]         mesh_q, how_q;
  logic               err_q;

  // locate and corners
  logic signed [49:0] ratio_x, ratio_y;
  logic [3:0]         cx, cy, nx, ny;
  logic [15:0]        fx, fy;
  logic [1:0]         k;
  corner_t            corners [4];
  logic signed [15:0] z1_q;
  logic signed [27:0] p_q;
  logic               q_neg;
  logic [DVD_W-1:0]   dvd;
  logic [9:0]         rem;
  logic [5:0]         div_cnt;

  // lerp unit
  logic [1:0]         j;
  corner_t            diff_q, a_q, lv, rv, off;
  logic [15:0]        f_q;
  logic [39:0]        plo;
  logic signed [40:0] phi;
  logic signed [PROD_W-1:0] prod;

  // memory port
  logic signed [15:0] mem [MEM_DEPTH];
  logic signed [15:0] rdata;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               mem_we;
  logic signed [15:0] wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // item checks at the command port
  logic q_fail;
  assign q_fail = (mesh_sel == MESH_FIRST) ||
                  (mesh_sel == MESH_SECOND && (nz_cnt[0] == '0 || nz_cnt[1] == '0));

  logic in_grid;
  assign in_grid = ({1'b0, col_q} < 5'(POINTS_X)) && ({1'b0, row_q} < 5'(POINTS_Y));

  // corner address for the current corner
  logic [3:0] k_col, k_row;
  assign k_col = k[1] ? nx : cx;
  assign k_row = k[0] ? ny : cy;

  // divider step
  logic [10:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign q_bit  = rem_sh >= {1'b0, den_mag};

  // lerp operand select
  corner_t     la, lb;
  logic [15:0] lf;
  always_comb begin
    unique case (j)
      2'd0:    begin la = corners[0]; lb = corners[1]; lf = fy; end
      2'd1:    begin la = corners[2]; lb = corners[3]; lf = fy; end
      default: begin la = lv;         lb = rv;         lf = fx; end
    endcase
  end

  logic signed [PROD_W-1:0] lerp_res, z_full;
  assign lerp_res = PROD_W'(a_q) + rdiv16(prod);
  assign z_full   = rdiv16(PROD_W'(off));

  // blend quotient and corner
  corner_t q_val, blend_corner;
  assign q_val        = q_neg ? -corner_t'({5'b0, dvd}) : corner_t'({5'b0, dvd});
  assign blend_corner = corner_t'({{16{z1_q[15]}}, z1_q, 16'b0}) + q_val;

  // absolute blend product
  logic [26:0] p_mag;
  assign p_mag = p_q[27] ? 27'(-p_q) : p_q[26:0];

  // next state and memory port control
  always_comb begin
    state_next = state;
    rd_addr    = slot_addr(mesh_q, k_col, k_row);
    mem_we     = 1'b0;
    wr_addr    = slot_addr(mesh_q, col_q, row_q);
    wdata      = height_q;
    unique case (state)
      S_CLR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wdata   = '0;
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        rd_addr = slot_addr(mesh_sel, point_col, point_row);
        if (start) begin
          if (action)       state_next = S_WR;
          else if (!q_fail) state_next = S_LOC;
        end
      end
      S_WR: begin
        mem_we     = in_grid;
        state_next = S_IDLE;
      end
      S_LOC:  state_next = S_CELL;
      S_CELL: state_next = S_RD1;
      S_RD1: begin
        rd_addr    = slot_addr((how_q == HOW_DIRECT) ? MESH_ORIG : MESH_FIRST, k_col, k_row);
        state_next = S_RD2;
      end
      S_RD2: begin
        rd_addr = slot_addr(MESH_SECOND, k_col, k_row);
        if (how_q == HOW_BLEND) state_next = S_MULP;
        else if (k == 2'd3)     state_next = S_LA;
        else                    state_next = S_RD1;
      end
      S_MULP:  state_next = S_DIVLD;
      S_DIVLD: state_next = S_DIV;
      S_DIV:   if (div_cnt == 6'(DVD_W - 1)) state_next = S_DIVEND;
      S_DIVEND: state_next = (k == 2'd3) ? S_LA : S_RD1;
      S_LA: state_next = S_LB;
      S_LB: state_next = S_LC;
      S_LC: state_next = S_LD;
      S_LD: state_next = (j == 2'd2) ? S_FIN : S_LA;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      nz_cnt[0] <= '0;
      nz_cnt[1] <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
      // nonzero point counts follow each write
      if (state == S_WR) begin
        done <= 1'b1;
        if (in_grid && mesh_q != MESH_ORIG) begin
          if (rdata != '0 && height_q == '0)
            nz_cnt[mesh_q[1]] <= nz_cnt[mesh_q[1]] - 1'b1;
          else if (rdata == '0 && height_q != '0)
            nz_cnt[mesh_q[1]] <= nz_cnt[mesh_q[1]] + 1'b1;
        end
      end
      if (state == S_IDLE && start && !action && q_fail) done <= 1'b1;
      if (state == S_FIN) done <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        act_q    <= action;
        pos_x_q  <= pos_x;
        pos_y_q  <= pos_y;
        col_q    <= point_col;
        row_q    <= point_row;
        height_q <= point_height;
        mesh_q   <= mesh_sel;
        k        <= '0;
        j        <= '0;
        if (mesh_sel == MESH_SECOND && first_mesh_temp == second_mesh_temp) begin
          how_q <= HOW_FIRST;
          err_q <= 1'b1;
        end else begin
          how_q <= (mesh_sel == MESH_SECOND) ? HOW_BLEND : HOW_DIRECT;
          err_q <= 1'b0;
        end
        if (start && !action && q_fail) begin
          z_offset   <= '0;
          mesh_error <= 1'b1;
        end
      end
      S_WR: begin
        z_offset   <= '0;
        mesh_error <= 1'b0;
      end
      // grid position times reciprocal spacing
      S_LOC: begin
        ratio_x <= ($signed({pos_x_q[23], pos_x_q}) - $signed({grid_origin_x[23], grid_origin_x}))
                   * $signed({1'b0, cells_per_unit_x});
        ratio_y <= ($signed({pos_y_q[23], pos_y_q}) - $signed({grid_origin_y[23], grid_origin_y}))
                   * $signed({1'b0, cells_per_unit_y});
      end
      // cell and fraction, clamped at both edges
      S_CELL: begin
        if (ratio_x < 0) begin
          cx <= '0; fx <= '0; nx <= (POINTS_X > 1) ? 4'd1 : 4'd0;
        end else if (ratio_x[49:24] >= 26'(POINTS_X - 1)) begin
          cx <= 4'(POINTS_X - 1); fx <= '0; nx <= 4'(POINTS_X - 1);
        end else begin
          cx <= ratio_x[27:24]; fx <= ratio_x[23:8]; nx <= ratio_x[27:24] + 1'b1;
        end
        if (ratio_y < 0) begin
          cy <= '0; fy <= '0; ny <= (POINTS_Y > 1) ? 4'd1 : 4'd0;
        end else if (ratio_y[49:24] >= 26'(POINTS_Y - 1)) begin
          cy <= 4'(POINTS_Y - 1); fy <= '0; ny <= 4'(POINTS_Y - 1);
        end else begin
          cy <= ratio_y[27:24]; fy <= ratio_y[23:8]; ny <= ratio_y[27:24] + 1'b1;
        end
      end
      S_RD2: begin
        z1_q <= rdata;
        if (how_q != HOW_BLEND) begin
          corners[k] <= corner_t'({{16{rdata[15]}}, rdata, 16'b0});
          k          <= k + 1'b1;
        end
      end
      // temperature offset times height difference
      S_MULP: begin
        p_q <= temp_dt * ($signed({rdata[15], rdata}) - $signed({z1_q[15], z1_q}));
      end
      S_DIVLD: begin
        q_neg   <= p_q[27] ^ temp_den[10];
        dvd     <= DVD_W'({p_mag, 16'b0}) + DVD_W'(den_mag[9:1]);
        rem     <= '0;
        div_cnt <= '0;
      end
      // one quotient bit per cycle
      S_DIV: begin
        rem     <= q_bit ? 10'(rem_sh - {1'b0, den_mag}) : rem_sh[9:0];
        dvd     <= {dvd[DVD_W-2:0], q_bit};
        div_cnt <= div_cnt + 1'b1;
      end
      S_DIVEND: begin
        corners[k] <= blend_corner;
        k          <= k + 1'b1;
      end
      S_LA: begin
        diff_q <= lb - la;
        a_q    <= la;
        f_q    <= lf;
      end
      // split product, two 24 by 16 multiplies
      S_LB: begin
        plo <= diff_q[23:0] * f_q;
        phi <= $signed(diff_q[47:24]) * $signed({1'b0, f_q});
      end
      S_LC: begin
        prod <= (PROD_W'(phi) <<< 24) + PROD_W'(plo);
      end
      S_LD: begin
        j <= j + 1'b1;
        unique case (j)
          2'd0:    lv  <= lerp_res[CORNER_W-1:0];
          2'd1:    rv  <= lerp_res[CORNER_W-1:0];
          default: off <= lerp_res[CORNER_W-1:0];
        endcase
      end
      // final rounding and saturation
      S_FIN: begin
        mesh_error <= err_q;
        if (z_full > PROD_W'(32767))       z_offset <= 16'sh7fff;
        else if (z_full < -PROD_W'(32768)) z_offset <= -16'sh8000;
        else                               z_offset <= z_full[15:0];
      end
      default: ;
    endcase
  end

  a_wr_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> $past(act_q || (start && action)))
    else $error("write-back without a write item");

  a_nz_bound: assert property (@(posedge clk) disable iff (rst)
    (nz_cnt[0] <= 9'(MESH_SLOTS)) && (nz_cnt[1] <= 9'(MESH_SLOTS)))
    else $error("nonzero count out of range");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < 6'(DVD_W)))
    else $error("divider ran past its length");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither worked on nor answered");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_WR || state == S_FIN || state == S_IDLE))
    else $error("result strobe from a working state");

endmodule

// ----- bench/bmbc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmbc_checker
// Watches the command, result and config channels of the bed mesh correction,
// keeps its own copy of the meshes and registers, works out the z offset and
// error flag of every accepted word and compares them with each result.
// ----------------------------------------------------------------------------
module bmbc_checker
  import bmbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               action,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [3:0]         point_col,
  input  logic [3:0]         point_row,
  input  logic signed [15:0] point_height,
  input  logic               done,
  input  logic signed [15:0] z_offset,
  input  logic               mesh_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] z;
    logic               err;
  } correction_t;

  correction_t        corr_q[$];
  logic signed [15:0] heights [MESH_COUNT][16][16];
  int                 filled [2];

  logic signed [23:0] org_x, org_y;
  logic [23:0]        cpu_x, cpu_y;
  logic [1:0]         mesh_sel;
  logic [8:0]         t_bed, t_first, t_second;

  // round to nearest, halves away from zero, positive divisor
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // grid index and Q0.16 fraction along one axis
  function automatic void find_cell(longint pos, longint org, longint factor,
                                    output int grid_idx, output longint frac);
    longint ratio;
    ratio = (pos - org) * factor;
    grid_idx = 0;
    frac = 0;
    if (ratio >= 0) begin
      if ((ratio >>> 24) >= 15) grid_idx = 15;
      else begin
        grid_idx = int'(ratio >>> 24);
        frac = (ratio & 64'hFFFFFF) >>> 8;
      end
    end
  endfunction

  // corner height in Q.16 for one grid point
  function automatic longint corner_q16(logic [1:0] how, int c, int r);
    longint z1, z2, t, num, den;
    if (how == HOW_DIRECT) return longint'(heights[0][c][r]) * 65536;
    z1 = heights[1][c][r];
    if (how == HOW_FIRST) return z1 * 65536;
    z2 = heights[2][c][r];
    t = t_bed;
    if (t == 0) t = (longint'(t_first) + longint'(t_second)) / 2;
    num = (t - t_first) * (z2 - z1) * 65536;
    den = longint'(t_second) - longint'(t_first);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return z1 * 65536 + round_div(num, den);
  endfunction

  // apply one word to the mirrored store and return its correction
  function automatic correction_t correct_word();
    correction_t res;
    logic [1:0]  m, how;
    int          cx, cy, nx, ny;
    longint      fx, fy, c00, c01, c10, c11, lft, rgt, off, z;
    res = '0;
    m = (mesh_sel == MESH_FIRST || mesh_sel == MESH_SECOND) ? mesh_sel : MESH_ORIG;
    if (action) begin
      if (m != MESH_ORIG) begin
        if (heights[m][point_col][point_row] != 0 && point_height == 0) filled[m-1]--;
        else if (heights[m][point_col][point_row] == 0 && point_height != 0) filled[m-1]++;
      end
      heights[m][point_col][point_row] = point_height;
      return res;
    end
    if (m == MESH_FIRST || (m == MESH_SECOND && (filled[0] == 0 || filled[1] == 0))) begin
      res.err = 1'b1;
      return res;
    end
    how = HOW_DIRECT;
    if (m == MESH_SECOND) begin
      if (t_first == t_second) begin
        how = HOW_FIRST;
        res.err = 1'b1;
      end else how = HOW_BLEND;
    end
    find_cell(pos_x, org_x, cpu_x, cx, fx);
    find_cell(pos_y, org_y, cpu_y, cy, fy);
    nx = (cx < 15) ? cx + 1 : cx;
    ny = (cy < 15) ? cy + 1 : cy;
    c00 = corner_q16(how, cx, cy);
    c01 = corner_q16(how, cx, ny);
    c10 = corner_q16(how, nx, cy);
    c11 = corner_q16(how, nx, ny);
    lft = c00 + round_div((c01 - c00) * fy, 65536);
    rgt = c10 + round_div((c11 - c10) * fy, 65536);
    off = lft + round_div((rgt - lft) * fx, 65536);
    z = round_div(off, 65536);
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    res.z = z[15:0];
    return res;
  endfunction

  assign pending = corr_q.size();

  // mirror config, predict accepted words, compare results
  always @(posedge clk) begin
    correction_t want;
    if (rst) begin
      corr_q.delete();
      fail_count <= 0;
      filled = '{0, 0};
      foreach (heights[m, c, r]) heights[m][c][r] = '0;
      {org_x, org_y, cpu_x, cpu_y} = '0;
      mesh_sel = MESH_ORIG;
      {t_bed, t_first, t_second} = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: org_x = cfg_data;
          REG_ORIGIN_Y: org_y = cfg_data;
          REG_CPU_X:    cpu_x = cfg_data;
          REG_CPU_Y:    cpu_y = cfg_data;
          REG_ACTIVE:   mesh_sel = cfg_data[1:0];
          REG_BED_TEMP: t_bed = cfg_data[8:0];
          REG_T1:       t_first = cfg_data[8:0];
          REG_T2:       t_second = cfg_data[8:0];
          default: ;
        endcase
      end
      if (done) begin
        if (corr_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result with no word pending z=%0d err=%0b",
                                        z_offset, mesh_error);
          fail_count <= fail_count + 1;
        end else begin
          want = corr_q.pop_front();
          if (want.z !== z_offset || want.err !== mesh_error) begin
            if (fail_count < 10)
              $display("ERROR: z_offset exp %0d got %0d, mesh_error exp %0b got %0b",
                       want.z, z_offset, want.err, mesh_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) corr_q.push_back(correct_word());
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the bed mesh correction with directed and random point writes and
// queries over many register settings, with random idle gaps, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import bmbc_pkg::*;

  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam int   LIMIT     = 2000000;

  logic               clk, rst, start, busy, action, done, mesh_error, cfg_we;
  logic signed [23:0] pos_x, pos_y;
  logic [3:0]         point_col, point_row;
  logic signed [15:0] point_height, z_offset;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;
  int                 fail_count, pending, cycles;
  int                 n_query, n_write, n_phase;
  bit                 gaps_on;
  logic signed [23:0] org_x, org_y;
  int                 span_x, span_y;

  bed_mesh_bilinear_correction u_top (.*);
  bmbc_checker u_chk (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one command word, held until accepted, then maybe an idle burst
  task automatic send_word(logic act, logic [23:0] x, logic [23:0] y,
                           logic [3:0] c, logic [3:0] r, logic [15:0] h);
    start <= 1'b1;
    action <= act;
    pos_x <= x;
    pos_y <= y;
    point_col <= c;
    point_row <= r;
    point_height <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_WRITE) n_write++;
    else n_query++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drain, then write registers while idle
  task automatic set_regs(logic [23:0] ox, logic [23:0] oy, logic [23:0] kx,
                          logic [23:0] ky, logic [1:0] m, logic [8:0] tb_,
                          logic [8:0] t1, logic [8:0] t2);
    logic [23:0] vals [8];
    vals = '{ox, oy, kx, ky, 24'(m), 24'(tb_), 24'(t1), 24'(t2)};
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    org_x = ox;
    org_y = oy;
    span_x = (kx == 0) ? 4096 : (kx > 24'd65536 ? 64 : 16 * (24'hFFFFFF / kx + 1));
    span_y = (ky == 0) ? 4096 : (ky > 24'd65536 ? 64 : 16 * (24'hFFFFFF / ky + 1));
    n_phase++;
  endtask

  // query near the grid, sometimes anywhere
  task automatic rand_query();
    if ($urandom_range(0, 4) == 0)
      send_word(ACT_QUERY, 24'($urandom), 24'($urandom), 4'($urandom),
                4'($urandom), 16'($urandom));
    else send_word(ACT_QUERY, 24'(org_x + $urandom_range(0, span_x) - span_x / 16),
                   24'(org_y + $urandom_range(0, span_y) - span_y / 16),
                   4'($urandom), 4'($urandom), 16'($urandom));
  endtask

  // random height, with zeros now and then to clear points
  function automatic logic [15:0] rand_height();
    if ($urandom_range(0, 7) == 0) return 16'd0;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 4000)) - 2000);
  endfunction

  // stimulus
  initial begin
    logic [23:0] kx, ky;
    logic [8:0]  t1, t2;
    cycles = 0;
    {n_query, n_write, n_phase} = '0;
    gaps_on = 1'b1;
    rst <= 1'b1;
    start <= 1'b0;
    action <= ACT_QUERY;
    pos_x <= '0;
    pos_y <= '0;
    point_col <= '0;
    point_row <= '0;
    point_height <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: original mesh, extremes of heights and positions
    set_regs(24'd0, 24'd0, 24'd4096, 24'd4096, MESH_ORIG, 9'd0, 9'd0, 9'd0);
    send_word(ACT_WRITE, '0, '0, 4'd0, 4'd0, 16'sh7FFF);
    send_word(ACT_WRITE, '0, '0, 4'd1, 4'd1, 16'sh8000);
    send_word(ACT_WRITE, '0, '0, 4'd15, 4'd15, 16'sh7FFF);
    send_word(ACT_WRITE, '0, '0, 4'd14, 4'd15, 16'sh8000);
    send_word(ACT_QUERY, 24'd2048, 24'd2048, '0, '0, '0);
    send_word(ACT_QUERY, 24'h800000, 24'h7FFFFF, '0, '0, '0);
    send_word(ACT_QUERY, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0);
    send_word(ACT_QUERY, 24'd57000, 24'd61439, '0, '0, '0);
    // unused selector acts as original; extreme origin and scale
    set_regs(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 2'd3, 9'd0, 9'd0, 9'd0);
    send_word(ACT_QUERY, 24'h7FFFFF, 24'h800000, '0, '0, '0);
    send_word(ACT_QUERY, 24'h800001, 24'h7FFFFF, '0, '0, '0);
    // first mesh: always an error; write to it
    set_regs(24'd0, 24'd0, 24'd4096, 24'd4096, MESH_FIRST, 9'd60, 9'd50, 9'd90);
    send_word(ACT_QUERY, 24'd100, 24'd100, '0, '0, '0);
    send_word(ACT_WRITE, '0, '0, 4'd2, 4'd3, 16'sd500);
    // second mesh empty: error
    set_regs(24'd0, 24'd0, 24'd4096, 24'd4096, MESH_SECOND, 9'd60, 9'd50, 9'd90);
    send_word(ACT_QUERY, 24'd10000, 24'd12000, '0, '0, '0);
    send_word(ACT_WRITE, '0, '0, 4'd2, 4'd3, 16'sh8000);
    send_word(ACT_QUERY, 24'd9000, 24'd13000, '0, '0, '0);
    // target unset, reversed and extreme temperatures
    set_regs(24'd0, 24'd0, 24'd4096, 24'd4096, MESH_SECOND, 9'd0, 9'd511, 9'd0);
    send_word(ACT_QUERY, 24'd9000, 24'd13000, '0, '0, '0);
    set_regs(24'd0, 24'd0, 24'd4096, 24'd4096, MESH_SECOND, 9'd511, 9'd1, 9'd0);
    send_word(ACT_QUERY, 24'd8500, 24'd13500, '0, '0, '0);
    // equal temperatures: first mesh values with error
    set_regs(24'd0, 24'd0, 24'd4096, 24'd4096, MESH_SECOND, 9'd70, 9'd80, 9'd80);
    send_word(ACT_QUERY, 24'd9000, 24'd13000, '0, '0, '0);
    // clear the only point of the second mesh, back to the empty error
    send_word(ACT_WRITE, '0, '0, 4'd2, 4'd3, 16'sd0);
    send_word(ACT_QUERY, 24'd9000, 24'd13000, '0, '0, '0);

    // random phases
    for (int p = 0; p < 14; p++) begin
      logic [1:0] m;
      m = (p < 3) ? 2'(p % 3) : 2'($urandom_range(0, 3));
      if (p >= 4 && $urandom_range(0, 2) != 0) m = MESH_SECOND;
      case ($urandom_range(0, 5))
        0: kx = 24'hFFFFFF;
        1: kx = 24'd0;
        default: kx = 24'($urandom_range(256, 65536));
      endcase
      case ($urandom_range(0, 5))
        0: ky = 24'hFFFFFF;
        1: ky = 24'd0;
        default: ky = 24'($urandom_range(256, 65536));
      endcase
      t1 = ($urandom_range(0, 5) == 0) ? 9'd511 : 9'($urandom_range(20, 120));
      t2 = ($urandom_range(0, 5) == 0) ? t1 : 9'($urandom);
      set_regs($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 8000)),
               $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 8000)),
               kx, ky, m, $urandom_range(0, 3) == 0 ? 9'd0 : 9'($urandom), t1, t2);
      if (p == 13) gaps_on = 1'b0;
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(0, 99) < (m == MESH_ORIG || p < 3 ? 50 : 25))
          send_word(ACT_WRITE, 24'($urandom), 24'($urandom), 4'($urandom),
                    4'($urandom), rand_height());
        else rand_query();
      end
    end

    // drain and settle
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("covered %0d queries and %0d point writes over %0d register settings",
             n_query, n_write, n_phase);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
